[sv/dtlp_pkg.sv]
package dtlp_pkg;

  localparam int ByteW = 8;

  localparam logic [ByteW-1:0] ChLt    = 8'h3C;
  localparam logic [ByteW-1:0] ChGt    = 8'h3E;
  localparam logic [ByteW-1:0] ChSlash = 8'h2F;
  localparam logic [ByteW-1:0] ChP     = 8'h50;
  localparam logic [ByteW-1:0] ChB     = 8'h42;
  localparam logic [ByteW-1:0] ChI     = 8'h49;
  localparam logic [ByteW-1:0] ChNl    = 8'h0A;
  localparam logic [ByteW-1:0] CaseGap = 8'h20;

  typedef enum logic [4:0] {
    S_OPEN_P_LT  = 5'd0,
    S_OPEN_P_CH  = 5'd1,
    S_OPEN_P_GT  = 5'd2,
    S_OPEN_B_LT  = 5'd3,
    S_OPEN_B_CH  = 5'd4,
    S_OPEN_B_GT  = 5'd5,
    S_WORD       = 5'd6,
    S_CLOSE_B_SL = 5'd7,
    S_CLOSE_B_CH = 5'd8,
    S_CLOSE_B_GT = 5'd9,
    S_OPEN_I_LT  = 5'd10,
    S_OPEN_I_CH  = 5'd11,
    S_OPEN_I_GT  = 5'd12,
    S_TYPE       = 5'd13,
    S_CLOSE_I_SL = 5'd14,
    S_CLOSE_I_CH = 5'd15,
    S_CLOSE_I_GT = 5'd16,
    S_PREDEF     = 5'd17,
    S_DEF        = 5'd18,
    S_WAIT       = 5'd19
  } parse_state_t;

  // decode result handed from the decoder to the output stage
  typedef struct packed {
    logic             emit;
    logic [ByteW-1:0] char_val;
  } dtlp_result_t;

  function automatic logic is_letter(input logic [ByteW-1:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

endpackage

[sv/dtlp_decode.sv]
module dtlp_decode (
  input  dtlp_pkg::parse_state_t         state,
  input  logic [dtlp_pkg::ByteW-1:0]     byte_val,
  output dtlp_pkg::parse_state_t         state_next,
  output dtlp_pkg::dtlp_result_t         result
);

  // expect one exact byte, else drop to the wait state
  function automatic dtlp_pkg::parse_state_t expect_byte(
    input logic [dtlp_pkg::ByteW-1:0] c,
    input logic [dtlp_pkg::ByteW-1:0] want,
    input dtlp_pkg::parse_state_t     nxt
  );
    return (c == want) ? nxt : dtlp_pkg::S_WAIT;
  endfunction

  // tag opener awaited: skip all but '<' and '>'
  function automatic dtlp_pkg::parse_state_t await_open(
    input logic [dtlp_pkg::ByteW-1:0] c,
    input dtlp_pkg::parse_state_t     self,
    input dtlp_pkg::parse_state_t     nxt
  );
    dtlp_pkg::parse_state_t r;
    r = self;
    if (c == dtlp_pkg::ChLt) r = nxt;
    else if (c == dtlp_pkg::ChGt) r = dtlp_pkg::S_WAIT;
    return r;
  endfunction

  always_comb begin
    state_next      = dtlp_pkg::S_WAIT;
    result.emit     = 1'b0;
    result.char_val = byte_val;
    unique case (state)
      dtlp_pkg::S_OPEN_P_LT:
        state_next = await_open(byte_val, dtlp_pkg::S_OPEN_P_LT, dtlp_pkg::S_OPEN_P_CH);
      dtlp_pkg::S_OPEN_P_CH:
        state_next = expect_byte(byte_val, dtlp_pkg::ChP, dtlp_pkg::S_OPEN_P_GT);
      dtlp_pkg::S_OPEN_P_GT:
        state_next = expect_byte(byte_val, dtlp_pkg::ChGt, dtlp_pkg::S_OPEN_B_LT);
      dtlp_pkg::S_OPEN_B_LT:
        state_next = await_open(byte_val, dtlp_pkg::S_OPEN_B_LT, dtlp_pkg::S_OPEN_B_CH);
      dtlp_pkg::S_OPEN_B_CH:
        state_next = expect_byte(byte_val, dtlp_pkg::ChB, dtlp_pkg::S_OPEN_B_GT);
      dtlp_pkg::S_OPEN_B_GT:
        state_next = expect_byte(byte_val, dtlp_pkg::ChGt, dtlp_pkg::S_WORD);
      dtlp_pkg::S_WORD: begin
        if (dtlp_pkg::is_letter(byte_val)) begin
          result.emit     = 1'b1;
          result.char_val = (byte_val <= 8'h5A) ? (byte_val + dtlp_pkg::CaseGap) : byte_val;
          state_next      = dtlp_pkg::S_WORD;
        end else if (byte_val == dtlp_pkg::ChLt) begin
          result.emit     = 1'b1;
          result.char_val = dtlp_pkg::ChNl;
          state_next      = dtlp_pkg::S_CLOSE_B_SL;
        end
      end
      dtlp_pkg::S_CLOSE_B_SL:
        state_next = expect_byte(byte_val, dtlp_pkg::ChSlash, dtlp_pkg::S_CLOSE_B_CH);
      dtlp_pkg::S_CLOSE_B_CH:
        state_next = expect_byte(byte_val, dtlp_pkg::ChB, dtlp_pkg::S_CLOSE_B_GT);
      dtlp_pkg::S_CLOSE_B_GT:
        state_next = expect_byte(byte_val, dtlp_pkg::ChGt, dtlp_pkg::S_OPEN_I_LT);
      dtlp_pkg::S_OPEN_I_LT:
        state_next = await_open(byte_val, dtlp_pkg::S_OPEN_I_LT, dtlp_pkg::S_OPEN_I_CH);
      dtlp_pkg::S_OPEN_I_CH:
        state_next = expect_byte(byte_val, dtlp_pkg::ChI, dtlp_pkg::S_OPEN_I_GT);
      dtlp_pkg::S_OPEN_I_GT:
        state_next = expect_byte(byte_val, dtlp_pkg::ChGt, dtlp_pkg::S_TYPE);
      dtlp_pkg::S_TYPE: begin
        result.emit = 1'b1;
        if (byte_val == dtlp_pkg::ChLt) begin
          result.char_val = dtlp_pkg::ChNl;
          state_next      = dtlp_pkg::S_CLOSE_I_SL;
        end else begin
          state_next = dtlp_pkg::S_TYPE;
        end
      end
      dtlp_pkg::S_CLOSE_I_SL:
        state_next = expect_byte(byte_val, dtlp_pkg::ChSlash, dtlp_pkg::S_CLOSE_I_CH);
      dtlp_pkg::S_CLOSE_I_CH:
        state_next = expect_byte(byte_val, dtlp_pkg::ChI, dtlp_pkg::S_CLOSE_I_GT);
      dtlp_pkg::S_CLOSE_I_GT:
        state_next = expect_byte(byte_val, dtlp_pkg::ChGt, dtlp_pkg::S_PREDEF);
      dtlp_pkg::S_PREDEF: begin
        if (dtlp_pkg::is_letter(byte_val)) begin
          result.emit = 1'b1;
          state_next  = dtlp_pkg::S_DEF;
        end else begin
          state_next = dtlp_pkg::S_PREDEF;
        end
      end
      dtlp_pkg::S_DEF: begin
        result.emit = 1'b1;
        if (byte_val == dtlp_pkg::ChLt) begin
          result.char_val = dtlp_pkg::ChNl;
          state_next      = dtlp_pkg::S_WAIT;
        end else begin
          state_next = dtlp_pkg::S_DEF;
        end
      end
      // wait state, and any code that is not a state, leave only on newline
      default:
        state_next = (byte_val == dtlp_pkg::ChNl) ? dtlp_pkg::S_OPEN_P_LT : dtlp_pkg::S_WAIT;
    endcase
  end

endmodule

[sv/dtlp_out_stage.sv]
module dtlp_out_stage (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic [dtlp_pkg::ByteW-1:0] load_char,
  output logic                       free,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [dtlp_pkg::ByteW-1:0] out_char
);

  // room for a new item when empty or being drained this cycle
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= load_char;
    end
  end

endmodule

[sv/dictionary_tag_line_parser.sv]
// Dictionary tag line parser: takes one text byte per item and walks lines of
// the form <P><B>word</B><I>type</I>definition<, giving zero or one output
// item per input byte: the word lowercased, the type and the definition raw,
// each ended by a newline. A mismatch makes the block skip bytes until a
// newline restarts the line. One item is accepted every cycle unless in_ready
// drops; a result passes through the input register, then the result
// register. The only stall comes from the result register: when it holds an
// item that is not taken and the byte in the input register would give
// another, in_ready drops until the result is taken.
module dictionary_tag_line_parser (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [dtlp_pkg::ByteW-1:0] in_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [dtlp_pkg::ByteW-1:0] out_char
);

  // input register
  logic                       s1_valid;
  logic [dtlp_pkg::ByteW-1:0] s1_byte;

  // parser state
  dtlp_pkg::parse_state_t state;
  dtlp_pkg::parse_state_t state_next;

  dtlp_pkg::dtlp_result_t result;
  logic                   out_free;
  logic                   s1_adv;

  // byte in the input register moves on unless its result has nowhere to go
  assign s1_adv   = s1_valid && (!result.emit || out_free);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= in_byte;
    end
  end

  // state advances once per consumed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtlp_pkg::S_OPEN_P_LT;
    end else if (s1_adv) begin
      state <= state_next;
    end
  end

  dtlp_decode u_decode (
    .state      (state),
    .byte_val   (s1_byte),
    .state_next (state_next),
    .result     (result)
  );

  dtlp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_adv && result.emit),
    .load_char (result.char_val),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char)
  );

  // reset puts the parser back at the start of a line
  a_reset_state: assert property (@(posedge clk)
    rst |=> (state == dtlp_pkg::S_OPEN_P_LT))
    else $error("parser not at line start after reset");

  // state only moves when a byte is consumed
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_adv |=> $stable(state))
    else $error("parser state moved without a consumed byte");

  // a word result is a lowercase letter or the closing newline
  a_word_char: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && result.emit && (state == dtlp_pkg::S_WORD)) |=>
      (((out_char >= 8'h61) && (out_char <= 8'h7A)) || (out_char == dtlp_pkg::ChNl)))
    else $error("word result is not lowercase letter or newline");

  // back-pressure only when both registers are occupied
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled without a full output register");

endmodule
